/* rtl/core/gpl_pkg.sv */
// gpl_pkg: shared types and constants for the gradient palette lookup block.
// No dependencies; imported by gpl_dp, gpl_ctrl and the top level.
package gpl_pkg;

  localparam int COLOR_W = 8;
  localparam int CHANNELS = 3;
  localparam logic [COLOR_W-1:0] CEILING_RESET = 8'd200;

  // operation codes carried on in_func
  typedef enum logic [1:0] {
    FUNC_LOOKUP  = 2'd0,
    FUNC_BEGIN   = 2'd1,
    FUNC_SEGMENT = 2'd2,
    FUNC_LOAD    = 2'd3
  } func_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;    // write one grey entry of the clearing pass
    logic rd_en;       // palette read for a lookup
    logic out_load;    // move read data into the output register
    logic ramp_begin;  // cursor to 0, color from the input beat
    logic load_wr;     // direct entry write, cursor/color to 0/black
    logic seg_start;   // latch segment end/target, start dividers
    logic div_step;    // one divider iteration
    logic fill_wr;     // write one interpolated entry
    logic seg_finish;  // cursor to end, target becomes current color
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic seg_empty;
    logic div_done;
    logic fill_last;
  } sts_t;

endpackage

/* rtl/core/gpl_div.sv */
// gpl_div: restoring divider, one quotient bit per cycle while step is high, unsigned.
// Depends on nothing; instantiated per color lane by gpl_dp.
module gpl_div #(
  parameter int DW = 24,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          step,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r;
  logic [VW-1:0] den_r;
  logic [DW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(DW);
    end else if (step && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      quo_r <= dividend;
    end else if (step && cnt_r != '0) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = cnt_r == '0;

endmodule

/* rtl/core/gpl_dp.sv */
// gpl_dp: palette memory, ramp cursor/color, lookup clamp, three divider lanes
// and interpolation accumulators. Depends on gpl_pkg and gpl_div.
module gpl_dp import gpl_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int FRACTION_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cmd_t                               cmd,
  output sts_t                               sts,
  input  logic                               cfg_we,
  input  logic [COLOR_W-1:0]                 cfg_data,
  input  logic signed [15:0]                 lookup_index,
  input  logic [9:0]                         segment_end,
  input  logic [7:0]                         entry_index,
  input  logic [CHANNELS-1:0][COLOR_W-1:0]   in_color,
  output logic [CHANNELS-1:0][COLOR_W-1:0]   out_color
);

  localparam int IW = $clog2(PALETTE_ENTRIES);
  localparam int DW = COLOR_W + FRACTION_BITS;
  localparam int AW = DW + 1;
  localparam logic [15:0] LAST16  = 16'(PALETTE_ENTRIES - 1);
  localparam logic [15:0] COUNT16 = 16'(PALETTE_ENTRIES);

  logic [CHANNELS*COLOR_W-1:0] mem [PALETTE_ENTRIES];

  logic [COLOR_W-1:0]                ceil_r;
  logic [IW-1:0]                     cursor_r;
  logic [CHANNELS-1:0][COLOR_W-1:0]  color_r;
  logic [IW-1:0]                     clr_idx_r;
  logic [IW-1:0]                     end_r;
  logic [CHANNELS-1:0][COLOR_W-1:0]  tgt_r;
  logic [IW-1:0]                     fill_idx_r;
  logic [CHANNELS*COLOR_W-1:0]       rdata_r;
  logic [CHANNELS*COLOR_W-1:0]       out_r;

  logic [15:0]                       ceil16, lim16, sel16;
  logic [15:0]                       end16, endc16, entry16;
  logic [IW-1:0]                     rd_addr, end_idx, len;
  logic                              entry_ok;
  logic [CHANNELS-1:0]               lane_done;
  logic [CHANNELS-1:0][COLOR_W-1:0]  fill_color;
  logic                              wr_en;
  logic [IW-1:0]                     wr_addr;
  logic [CHANNELS*COLOR_W-1:0]       wr_data;

  // lookup clamp: negative -> 0, above ceiling -> ceiling, ceiling capped at last entry
  assign ceil16  = {8'd0, ceil_r};
  assign lim16   = (ceil16 > LAST16) ? LAST16 : ceil16;
  assign sel16   = lookup_index[15] ? 16'd0 :
                   (($unsigned(lookup_index) > lim16) ? lim16 : $unsigned(lookup_index));
  assign rd_addr = sel16[IW-1:0];

  // segment end clamped to the last entry
  assign end16   = {6'd0, segment_end};
  assign endc16  = (end16 > LAST16) ? LAST16 : end16;
  assign end_idx = endc16[IW-1:0];
  assign len     = end_idx - cursor_r;

  assign entry16  = {8'd0, entry_index};
  assign entry_ok = entry16 < COUNT16;

  assign sts.clear_last = clr_idx_r == IW'(PALETTE_ENTRIES - 1);
  assign sts.seg_empty  = end_idx <= cursor_r;
  assign sts.div_done   = &lane_done;
  assign sts.fill_last  = IW'(fill_idx_r + 1'b1) == end_r;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic signed [COLOR_W:0] diff;
    logic [COLOR_W-1:0]      mag;
    logic [DW-1:0]           quo;
    logic signed [AW-1:0]    step;
    logic signed [AW-1:0]    acc_r;
    logic                    neg_r;

    assign diff = $signed({1'b0, in_color[ch]}) - $signed({1'b0, color_r[ch]});
    assign mag  = diff[COLOR_W] ? COLOR_W'(-diff) : diff[COLOR_W-1:0];

    gpl_div #(
      .DW(DW),
      .VW(IW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.seg_start),
      .step     (cmd.div_step),
      .dividend ({mag, {FRACTION_BITS{1'b0}}}),
      .divisor  (len),
      .quotient (quo),
      .done     (lane_done[ch])
    );

    // quotient of magnitudes, sign applied after: truncation toward zero
    assign step = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    always_ff @(posedge clk) begin
      if (cmd.seg_start) begin
        neg_r <= diff[COLOR_W];
        acc_r <= $signed({1'b0, color_r[ch], {FRACTION_BITS{1'b0}}});
      end else if (cmd.fill_wr) begin
        acc_r <= acc_r + step;
      end
    end

    assign fill_color[ch] = acc_r[FRACTION_BITS +: COLOR_W];
  end

  // single write port: clearing pass, direct load, ramp fill
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx_r;
    wr_data = {CHANNELS{COLOR_W'(clr_idx_r)}};
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.load_wr && entry_ok) begin
      wr_en   = 1'b1;
      wr_addr = entry16[IW-1:0];
      wr_data = in_color;
    end else if (cmd.fill_wr) begin
      wr_en   = 1'b1;
      wr_addr = fill_idx_r;
      wr_data = fill_color;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= rdata_r;
    end
    if (cmd.seg_start) begin
      end_r      <= end_idx;
      tgt_r      <= in_color;
      fill_idx_r <= cursor_r;
    end else if (cmd.fill_wr) begin
      fill_idx_r <= fill_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r    <= CEILING_RESET;
      cursor_r  <= '0;
      color_r   <= '0;
      clr_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        ceil_r <= cfg_data;
      end
      if (cmd.clear_wr) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.ramp_begin) begin
        cursor_r <= '0;
        color_r  <= in_color;
      end else if (cmd.load_wr) begin
        cursor_r <= '0;
        color_r  <= '0;
      end else if (cmd.seg_finish) begin
        cursor_r <= end_r;
        color_r  <= tgt_r;
      end
    end
  end

  assign out_color = out_r;

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_wr |-> fill_idx_r < end_r)
    else $error("ramp fill address at or beyond segment end");

  a_fill_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_wr |-> sts.div_done)
    else $error("ramp fill started before the step division finished");

endmodule

/* rtl/core/gpl_ctrl.sv */
// gpl_ctrl: sequencer for clearing pass, lookups and ramp segments; owns out_valid.
// Depends on gpl_pkg.
module gpl_ctrl import gpl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output cmd_t       cmd,
  input  sts_t       sts
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_DIV   = 6'b001000,
    S_FILL  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (func_t'(in_func))
            FUNC_LOOKUP: begin
              cmd.rd_en = 1'b1;
              state_nxt = S_LOOK;
            end
            FUNC_BEGIN: begin
              cmd.ramp_begin = 1'b1;
            end
            FUNC_SEGMENT: begin
              cmd.seg_start = 1'b1;
              state_nxt     = sts.seg_empty ? S_FIN : S_DIV;
            end
            FUNC_LOAD: begin
              cmd.load_wr = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FILL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.seg_finish = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_lookup_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("lookup read data not moved into the output register");

  a_lookup_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_LOOKUP) |=> state_r == S_LOOK)
    else $error("accepted lookup did not enter the read state");

  a_segment_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_SEGMENT)
      |=> (state_r == S_DIV || state_r == S_FIN))
    else $error("accepted segment did not start division or finish");

endmodule

/* rtl/core/gradient_palette_lookup_top.sv */
// gradient_palette_lookup_top: top level of the RGB palette with ramp writer.
// Depends on gpl_pkg, gpl_ctrl, gpl_dp (which holds gpl_div lanes).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in_     | input     | in_valid / in_ready  | func, lookup_index, segment_end,
//           |           |                      | entry_index, color_red/green/blue
//   out_    | output    | out_valid/out_ready  | out_red, out_green, out_blue
//   cfg_    | input     | cfg_valid/cfg_ready  | cfg_lookup_ceiling
//
// After reset a clearing pass writes the grey ramp, one entry a cycle, into
//   all PALETTE_ENTRIES entries; no input beat is taken until it ends.
// Lookup: the registered palette read port is followed by the output register;
//   a stalled output holds the block in the read state, and no new beat is taken there.
// Ramp begin and load entry finish in the idle state. Ramp segment: accept,
//   8 + FRACTION_BITS bit-serial divider steps per lane and a done check, then
//   one entry written per cycle and a finish; an empty segment goes to finish.
// cfg_ready is always high; the ceiling write is taken at any time.
module gradient_palette_lookup_top import gpl_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int FRACTION_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_lookup_index,
  input  logic [9:0]         in_segment_end,
  input  logic [7:0]         in_entry_index,
  input  logic [7:0]         in_color_red,
  input  logic [7:0]         in_color_green,
  input  logic [7:0]         in_color_blue,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  // lookup ceiling register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_lookup_ceiling
);

  cmd_t                              cmd;
  sts_t                              sts;
  logic [CHANNELS-1:0][COLOR_W-1:0]  in_color;
  logic [CHANNELS-1:0][COLOR_W-1:0]  out_color;

  // packed color: red in the top byte, matching the palette word layout
  assign in_color  = {in_color_red, in_color_green, in_color_blue};
  assign out_red   = out_color[2];
  assign out_green = out_color[1];
  assign out_blue  = out_color[0];
  assign cfg_ready = 1'b1;

  gpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  gpl_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_lookup_ceiling),
    .lookup_index (in_lookup_index),
    .segment_end  (in_segment_end),
    .entry_index  (in_entry_index),
    .in_color     (in_color),
    .out_color    (out_color)
  );

endmodule
